/* hdl/mcp0_pkg.sv */
// Shared types, codes, masks and helpers of the CP0 system-control register file.
// No dependencies; used by every file under hdl.
package mcp0_pkg;

	localparam int unsigned NUM_REGS = 32;

	// Command codes
	localparam logic [2:0] CMD_READ      = 3'd0;
	localparam logic [2:0] CMD_WRITE     = 3'd1;
	localparam logic [2:0] CMD_EXCEPTION = 3'd2;
	localparam logic [2:0] CMD_ADDR_ERR  = 3'd3;
	localparam logic [2:0] CMD_TLB_MISS  = 3'd4;

	// Register numbers
	localparam logic [4:0] REG_INDEX    = 5'd0;
	localparam logic [4:0] REG_RANDOM   = 5'd1;
	localparam logic [4:0] REG_ENTRYLO0 = 5'd2;
	localparam logic [4:0] REG_ENTRYLO1 = 5'd3;
	localparam logic [4:0] REG_CONTEXT  = 5'd4;
	localparam logic [4:0] REG_PAGEMASK = 5'd5;
	localparam logic [4:0] REG_WIRED    = 5'd6;
	localparam logic [4:0] REG_RSVD7    = 5'd7;
	localparam logic [4:0] REG_BADVADDR = 5'd8;
	localparam logic [4:0] REG_COUNT    = 5'd9;
	localparam logic [4:0] REG_ENTRYHI  = 5'd10;
	localparam logic [4:0] REG_COMPARE  = 5'd11;
	localparam logic [4:0] REG_STATUS   = 5'd12;
	localparam logic [4:0] REG_CAUSE    = 5'd13;
	localparam logic [4:0] REG_EPC      = 5'd14;
	localparam logic [4:0] REG_PRID     = 5'd15;
	localparam logic [4:0] REG_CONFIG   = 5'd16;
	localparam logic [4:0] REG_LLADDR   = 5'd17;
	localparam logic [4:0] REG_WATCHLO  = 5'd18;
	localparam logic [4:0] REG_WATCHHI  = 5'd19;
	localparam logic [4:0] REG_XCONTEXT = 5'd20;
	localparam logic [4:0] REG_RSVD21   = 5'd21;
	localparam logic [4:0] REG_RSVD25   = 5'd25;
	localparam logic [4:0] REG_PERR     = 5'd26;
	localparam logic [4:0] REG_TAGLO    = 5'd28;
	localparam logic [4:0] REG_TAGHI    = 5'd29;
	localparam logic [4:0] REG_ERROREPC = 5'd30;
	localparam logic [4:0] REG_RSVD31   = 5'd31;

	// Cause ExcCode values
	localparam logic [4:0] EXC_TLBL = 5'd2;
	localparam logic [4:0] EXC_ADEL = 5'd4;
	localparam logic [4:0] EXC_ADES = 5'd5;

	// Vectors
	localparam logic [31:0] VEC_GENERAL = 32'h8000_0180;
	localparam logic [31:0] VEC_REFILL  = 32'h8000_0000;

	// Write masks
	localparam logic [63:0] MASK_INDEX     = 64'h0000_0000_8000_003F;
	localparam logic [63:0] MASK_ENTRYLO   = 64'h0000_0000_3FFF_FFFF;
	localparam logic [63:0] MASK_CTX_WR    = 64'hFFFF_FFFF_FF80_0000;
	localparam logic [63:0] MASK_CTX_KEEP  = 64'h0000_0000_007F_FFF0;
	localparam logic [63:0] MASK_PAGEMASK  = 64'h0000_0000_01FF_E000;
	localparam logic [63:0] MASK_WIRED     = 64'h0000_0000_0000_003F;
	localparam logic [63:0] MASK_ENTRYHI   = 64'hC000_00FF_FFFF_E0FF;
	localparam logic [63:0] MASK_STATUS    = 64'h0000_0000_FFF7_FFFF;
	localparam logic [63:0] MASK_CAUSE_KP  = 64'h0000_0000_0FFF_FCFF;
	localparam logic [63:0] MASK_CFG_WR    = 64'h0000_0000_0F00_800F;
	localparam logic [63:0] MASK_CFG_KEEP  = 64'h0000_0000_F0FF_7FF0;
	localparam logic [63:0] MASK_LO32      = 64'h0000_0000_FFFF_FFFF;
	localparam logic [63:0] MASK_XCTX_WR   = 64'hFFFF_FFFE_0000_0000;
	localparam logic [63:0] MASK_PERR      = 64'h0000_0000_0000_00FF;
	localparam logic [63:0] MASK_ENTRYHI_M = 64'h0000_0000_FFFF_E000;

	typedef struct packed {
		logic [2:0]  command;
		logic [4:0]  reg_index;
		logic [63:0] write_value;
		logic [4:0]  exc_code;
		logic [1:0]  coproc_unit;
		logic        in_delay_slot;
		logic [31:0] current_pc;
		logic [63:0] bad_address;
		logic        is_read_access;
		logic        address_mapped;
	} req_t;

	typedef struct packed {
		logic [63:0] read_data;
		logic        redirect;
		logic [31:0] redirect_pc;
		logic        interrupt_request;
	} res_t;

	function automatic logic [63:0] reset_value(logic [4:0] idx);
		logic [63:0] v;
		case (idx)
			REG_RANDOM:   v = 64'h1F;
			REG_COUNT:    v = 64'h5000;
			REG_CAUSE:    v = 64'h5C;
			REG_CONTEXT:  v = 64'h007F_FFF0;
			REG_EPC:      v = '1;
			REG_BADVADDR: v = '1;
			REG_ERROREPC: v = '1;
			REG_PRID:     v = 64'hB22;
			REG_CONFIG:   v = 64'h7006_E463;
			REG_STATUS:   v = 64'h3400_0000;
			default:      v = '0;
		endcase
		return v;
	endfunction

	// Registers with no storage of their own read back the last written value
	function automatic logic is_unused(logic [4:0] idx);
		return (idx == REG_RSVD7) || (idx == REG_RSVD31) ||
			((idx >= REG_RSVD21) && (idx <= REG_RSVD25));
	endfunction

	function automatic logic [63:0] cause_code(logic [63:0] c, logic [4:0] code,
			logic [1:0] ce);
		logic [63:0] r;
		r = c;
		r[6:2] = code;
		r[29:28] = ce;
		return r;
	endfunction

	// EPC: sign-extended pc, backed up one word in a delay slot
	function automatic logic [63:0] epc_value(logic [31:0] pc, logic ds);
		logic [31:0] p;
		p = ds ? pc - 32'd4 : pc;
		return {{32{p[31]}}, p};
	endfunction

	function automatic logic [63:0] context_load(logic [63:0] ctx, logic [63:0] addr);
		logic [63:0] r;
		r = ctx;
		r[22:4] = addr[31:13];
		return r;
	endfunction

	function automatic logic [63:0] xcontext_load(logic [63:0] xctx, logic [63:0] addr);
		logic [63:0] r;
		r = xctx;
		r[30:4] = addr[39:13];
		r[32:31] = addr[62:61];
		return r;
	endfunction

endpackage

/* hdl/mcp0_regfile.sv */
// CP0 register array with its update logic and result formation.
// Depends on mcp0_pkg.
module mcp0_regfile (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            en,
	input  mcp0_pkg::req_t  req,
	output mcp0_pkg::res_t  res
);

	logic [63:0] regs_q [mcp0_pkg::NUM_REGS];
	logic [63:0] regs_nxt [mcp0_pkg::NUM_REGS];
	logic [63:0] last_q;
	logic [63:0] last_nxt;

	logic [63:0] rdata;
	logic        redir;
	logic [31:0] vec;
	logic [63:0] st;
	logic [63:0] cs;
	logic [63:0] old;

	always_comb begin
		regs_nxt = regs_q;
		last_nxt = last_q;
		rdata    = '0;
		redir    = 1'b0;
		vec      = '0;
		cs       = '0;
		old      = regs_q[req.reg_index];
		case (req.command)
			mcp0_pkg::CMD_READ: begin
				rdata = mcp0_pkg::is_unused(req.reg_index) ? last_q : old;
			end
			mcp0_pkg::CMD_WRITE: begin
				last_nxt = req.write_value;
				case (req.reg_index)
					mcp0_pkg::REG_COUNT, mcp0_pkg::REG_EPC, mcp0_pkg::REG_WATCHLO,
					mcp0_pkg::REG_WATCHHI, mcp0_pkg::REG_TAGLO, mcp0_pkg::REG_TAGHI,
					mcp0_pkg::REG_ERROREPC, mcp0_pkg::REG_RSVD31: begin
						regs_nxt[req.reg_index] = req.write_value;
					end
					mcp0_pkg::REG_INDEX: begin
						regs_nxt[req.reg_index] = req.write_value & mcp0_pkg::MASK_INDEX;
					end
					mcp0_pkg::REG_ENTRYLO0, mcp0_pkg::REG_ENTRYLO1: begin
						regs_nxt[req.reg_index] = req.write_value & mcp0_pkg::MASK_ENTRYLO;
					end
					mcp0_pkg::REG_CONTEXT: begin
						regs_nxt[req.reg_index] = (req.write_value & mcp0_pkg::MASK_CTX_WR) |
							(old & mcp0_pkg::MASK_CTX_KEEP);
					end
					mcp0_pkg::REG_PAGEMASK: begin
						regs_nxt[req.reg_index] = req.write_value & mcp0_pkg::MASK_PAGEMASK;
					end
					mcp0_pkg::REG_WIRED: begin
						regs_nxt[req.reg_index] = req.write_value & mcp0_pkg::MASK_WIRED;
					end
					mcp0_pkg::REG_ENTRYHI: begin
						regs_nxt[req.reg_index] = req.write_value & mcp0_pkg::MASK_ENTRYHI;
					end
					mcp0_pkg::REG_COMPARE: begin
						regs_nxt[req.reg_index] = req.write_value;
						regs_nxt[mcp0_pkg::REG_CAUSE][15] = 1'b0;
					end
					mcp0_pkg::REG_STATUS: begin
						regs_nxt[req.reg_index] = req.write_value & mcp0_pkg::MASK_STATUS;
					end
					mcp0_pkg::REG_CAUSE: begin
						regs_nxt[req.reg_index] = old & mcp0_pkg::MASK_CAUSE_KP;
					end
					mcp0_pkg::REG_CONFIG: begin
						regs_nxt[req.reg_index] = (req.write_value & mcp0_pkg::MASK_CFG_WR) |
							(old & mcp0_pkg::MASK_CFG_KEEP);
					end
					mcp0_pkg::REG_LLADDR: begin
						regs_nxt[req.reg_index] = (req.write_value & mcp0_pkg::MASK_LO32) |
							(old & ~mcp0_pkg::MASK_LO32);
					end
					mcp0_pkg::REG_XCONTEXT: begin
						regs_nxt[req.reg_index] = (req.write_value & mcp0_pkg::MASK_XCTX_WR) |
							(old & ~mcp0_pkg::MASK_XCTX_WR);
					end
					mcp0_pkg::REG_PERR: begin
						regs_nxt[req.reg_index] = req.write_value & mcp0_pkg::MASK_PERR;
					end
					default: begin
						// read-only and reserved: no change
					end
				endcase
			end
			mcp0_pkg::CMD_EXCEPTION: begin
				cs = mcp0_pkg::cause_code(regs_q[mcp0_pkg::REG_CAUSE], req.exc_code,
					req.coproc_unit);
				cs[31] = req.in_delay_slot;
				regs_nxt[mcp0_pkg::REG_CAUSE] = cs;
				regs_nxt[mcp0_pkg::REG_EPC] = mcp0_pkg::epc_value(req.current_pc,
					req.in_delay_slot);
				regs_nxt[mcp0_pkg::REG_STATUS][1] = 1'b1;
				redir = 1'b1;
				vec   = mcp0_pkg::VEC_GENERAL;
			end
			mcp0_pkg::CMD_ADDR_ERR: begin
				cs = mcp0_pkg::cause_code(regs_q[mcp0_pkg::REG_CAUSE],
					req.is_read_access ? mcp0_pkg::EXC_ADEL : mcp0_pkg::EXC_ADES, 2'd0);
				cs[31] = req.in_delay_slot;
				regs_nxt[mcp0_pkg::REG_CAUSE] = cs;
				regs_nxt[mcp0_pkg::REG_BADVADDR] = req.bad_address;
				regs_nxt[mcp0_pkg::REG_CONTEXT] = mcp0_pkg::context_load(
					regs_q[mcp0_pkg::REG_CONTEXT], req.bad_address);
				regs_nxt[mcp0_pkg::REG_XCONTEXT] = mcp0_pkg::xcontext_load(
					regs_q[mcp0_pkg::REG_XCONTEXT], req.bad_address);
				regs_nxt[mcp0_pkg::REG_EPC] = mcp0_pkg::epc_value(req.current_pc,
					req.in_delay_slot);
				regs_nxt[mcp0_pkg::REG_STATUS][1] = 1'b1;
				redir = 1'b1;
				vec   = mcp0_pkg::VEC_GENERAL;
			end
			mcp0_pkg::CMD_TLB_MISS: begin
				cs = mcp0_pkg::cause_code(regs_q[mcp0_pkg::REG_CAUSE], mcp0_pkg::EXC_TLBL,
					2'd0);
				regs_nxt[mcp0_pkg::REG_BADVADDR] = req.bad_address;
				regs_nxt[mcp0_pkg::REG_CONTEXT] = mcp0_pkg::context_load(
					regs_q[mcp0_pkg::REG_CONTEXT], req.bad_address);
				regs_nxt[mcp0_pkg::REG_ENTRYHI] = req.bad_address & mcp0_pkg::MASK_ENTRYHI_M;
				redir = 1'b1;
				if (!regs_q[mcp0_pkg::REG_STATUS][1]) begin
					cs[31] = req.in_delay_slot;
					regs_nxt[mcp0_pkg::REG_EPC] = mcp0_pkg::epc_value(req.current_pc,
						req.in_delay_slot);
					regs_nxt[mcp0_pkg::REG_STATUS][1] = 1'b1;
					vec = req.address_mapped ? mcp0_pkg::VEC_GENERAL : mcp0_pkg::VEC_REFILL;
				end else begin
					// nested miss: EPC, BD and EXL untouched
					vec = mcp0_pkg::VEC_GENERAL;
				end
				regs_nxt[mcp0_pkg::REG_CAUSE] = cs;
			end
			default: begin
				// unknown command: no effect
			end
		endcase
		st = regs_nxt[mcp0_pkg::REG_STATUS];
		res.read_data         = rdata;
		res.redirect          = redir;
		res.redirect_pc       = vec;
		res.interrupt_request = st[0] && (st[2:1] == 2'b00) &&
			(|(st[15:8] & regs_nxt[mcp0_pkg::REG_CAUSE][15:8]));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < mcp0_pkg::NUM_REGS; i++) begin
				regs_q[i] <= mcp0_pkg::reset_value(5'(i));
			end
			last_q <= '0;
		end else if (en) begin
			regs_q <= regs_nxt;
			last_q <= last_nxt;
		end
	end

endmodule

/* hdl/mips_cp0_register_file_core.sv */
// Top level of the CP0 system-control register file: request and result registers.
// Depends on mcp0_pkg and mcp0_regfile.
//
// Usage: a request is taken on any rising edge with start high; busy is
// always low, so one request can be issued every clock. Its result shows on
// res, with done high, for exactly one cycle: the request passes through the
// request register, then through the register update logic into the result
// register. The receiver cannot stall, so results must be captured on the
// cycle done is high. Every request gives one result, unknown commands
// included (all zero apart from interrupt_request). Register effects of a
// request are visible to the very next one. After reset the registers hold
// their architectural reset values; no clearing pass.
module mips_cp0_register_file_core (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	output logic            busy,
	input  mcp0_pkg::req_t  req,
	output logic            done,
	output mcp0_pkg::res_t  res
);

	// request stage
	logic            valid_s1;
	mcp0_pkg::req_t  req_s1;

	// result stage
	logic            done_q;
	mcp0_pkg::res_t  res_q;

	mcp0_pkg::res_t  res_comb;

	// single pass per request: never stalls the issuer
	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= start && !busy;
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy) begin
			req_s1 <= req;
		end
	end

	// register array updates on the same edge that captures the result
	mcp0_regfile u_regfile (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (valid_s1),
		.req    (req_s1),
		.res    (res_comb)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			res_q <= res_comb;
		end
	end

	assign done = done_q;
	assign res  = res_q;

endmodule

/* hdl/mcp0_checker.sv */
// Port-level checks for mips_cp0_register_file_core, attached by bind.
// Depends on mcp0_pkg.
module mcp0_checker (
	input logic            clk,
	input logic            arst_n,
	input logic            start,
	input logic            busy,
	input logic            done,
	input mcp0_pkg::res_t  res
);

	a_never_busy: assert property (@(posedge clk) disable iff (!arst_n) !busy)
		else $error("busy raised");

	a_req_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##2 done)
		else $error("request without result");

	a_no_spurious_result: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, 2))
		else $error("result without request");

	a_vector_only_on_redirect: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !res.redirect) |-> (res.redirect_pc == 32'd0))
		else $error("vector without redirect");

	a_no_data_on_redirect: assert property (@(posedge clk) disable iff (!arst_n)
		(done && res.redirect) |-> (res.read_data == 64'd0))
		else $error("read data on exception entry");

endmodule

bind mips_cp0_register_file_core mcp0_checker u_mcp0_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.done   (done),
	.res    (res)
);

/* bench/mips_cp0_register_file_core_test.sv */
// Self-checking bench for the CP0 system-control register file core.
// Depends on mcp0_pkg and mips_cp0_register_file_core; a shadow copy of the
// registers predicts each result and a monitor checks the result stream.
`timescale 1ns / 100ps

module mips_cp0_register_file_core_test;
	import mcp0_pkg::*;

	localparam int unsigned RANDOM_OPS  = 400;
	localparam int unsigned CYCLE_LIMIT = 60000;
	localparam int unsigned SETTLE_CLKS = 4;     // settling margin after the last result
	localparam logic [2:0]  CMD_UNUSED_LO = 3'd5; // commands with no effect
	localparam logic [2:0]  CMD_UNUSED_HI = 3'd7;

	// One entry of the stimulus queue: a request and the idle cycles that
	// follow it, or a drain marker that holds the sender off until every
	// outstanding result has come back.
	typedef struct {
		req_t        cmd;
		int unsigned hold_off;
		bit          drain;
	} cp0_op_t;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;
	logic start  = 1'b0;
	req_t req    = '0;
	logic busy;
	logic done;
	res_t res;

	cp0_op_t     op_q[$];
	res_t        cp0_result_q[$];
	cp0_op_t     next_op;
	res_t        want;
	int unsigned idle_left;
	int unsigned mismatch_count = 0;
	int unsigned result_count;
	int unsigned cycle_count = 0;
	int unsigned ri;

	// Shadow register file and the last value written by any write request
	logic [63:0] shadow_regs[32];
	logic [63:0] shadow_last_wr;

	mips_cp0_register_file_core i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.req    (req),
		.done   (done),
		.res    (res)
	);

	always #6 clk = ~clk;

	// ---------------------------------------------------------------- shadow
	function automatic void shadow_fault_code(logic [4:0] code, logic [1:0] ce);
		shadow_regs[REG_CAUSE][6:2]   = code;
		shadow_regs[REG_CAUSE][29:28] = ce;
	endfunction

	// EPC gets the faulting pc, one word back when it sits in a delay slot;
	// Cause BD tracks the delay slot flag.
	function automatic void shadow_save_epc(logic [31:0] pc, logic ds);
		logic [31:0] p;
		p = ds ? pc - 32'd4 : pc;
		shadow_regs[REG_CAUSE][31] = ds;
		shadow_regs[REG_EPC] = {{32{p[31]}}, p};
	endfunction

	function automatic void shadow_load_vaddr(logic [63:0] addr);
		shadow_regs[REG_BADVADDR] = addr;
		shadow_regs[REG_CONTEXT][22:4] = addr[31:13];
	endfunction

	// Applies one request to the shadow registers and returns its result.
	function automatic res_t predict_cp0_result(req_t r);
		res_t        o;
		logic [63:0] v;
		logic [63:0] old;
		logic [63:0] st;
		o   = '0;
		v   = r.write_value;
		old = shadow_regs[r.reg_index];
		case (r.command)
		CMD_READ: begin
			// registers without storage read back the last write
			if (r.reg_index == REG_RSVD7 || r.reg_index == REG_RSVD31 ||
					(r.reg_index >= REG_RSVD21 && r.reg_index <= REG_RSVD25))
				o.read_data = shadow_last_wr;
			else
				o.read_data = old;
		end
		CMD_WRITE: begin
			shadow_last_wr = v;
			case (r.reg_index)
			REG_COUNT, REG_EPC, REG_WATCHLO, REG_WATCHHI, REG_TAGLO, REG_TAGHI,
			REG_ERROREPC, REG_RSVD31:
				shadow_regs[r.reg_index] = v;
			REG_INDEX:
				shadow_regs[r.reg_index] = v & MASK_INDEX;
			REG_ENTRYLO0, REG_ENTRYLO1:
				shadow_regs[r.reg_index] = v & MASK_ENTRYLO;
			REG_CONTEXT:
				shadow_regs[r.reg_index] = (v & MASK_CTX_WR) | (old & MASK_CTX_KEEP);
			REG_PAGEMASK:
				shadow_regs[r.reg_index] = v & MASK_PAGEMASK;
			REG_WIRED:
				shadow_regs[r.reg_index] = v & MASK_WIRED;
			REG_ENTRYHI:
				shadow_regs[r.reg_index] = v & MASK_ENTRYHI;
			REG_COMPARE: begin
				shadow_regs[r.reg_index] = v;
				shadow_regs[REG_CAUSE][15] = 1'b0;
			end
			REG_STATUS:
				shadow_regs[r.reg_index] = v & MASK_STATUS;
			REG_CAUSE:
				shadow_regs[r.reg_index] = old & MASK_CAUSE_KP;
			REG_CONFIG:
				shadow_regs[r.reg_index] = (v & MASK_CFG_WR) | (old & MASK_CFG_KEEP);
			REG_LLADDR:
				shadow_regs[r.reg_index] = (v & MASK_LO32) | (old & ~MASK_LO32);
			REG_XCONTEXT:
				shadow_regs[r.reg_index] = (v & MASK_XCTX_WR) | (old & ~MASK_XCTX_WR);
			REG_PERR:
				shadow_regs[r.reg_index] = v & MASK_PERR;
			default: ;  // read-only and reserved registers
			endcase
		end
		CMD_EXCEPTION: begin
			shadow_fault_code(r.exc_code, r.coproc_unit);
			shadow_save_epc(r.current_pc, r.in_delay_slot);
			shadow_regs[REG_STATUS][1] = 1'b1;
			o.redirect    = 1'b1;
			o.redirect_pc = VEC_GENERAL;
		end
		CMD_ADDR_ERR: begin
			shadow_fault_code(r.is_read_access ? EXC_ADEL : EXC_ADES, 2'd0);
			shadow_load_vaddr(r.bad_address);
			shadow_regs[REG_XCONTEXT][30:4]  = r.bad_address[39:13];
			shadow_regs[REG_XCONTEXT][32:31] = r.bad_address[62:61];
			shadow_save_epc(r.current_pc, r.in_delay_slot);
			shadow_regs[REG_STATUS][1] = 1'b1;
			o.redirect    = 1'b1;
			o.redirect_pc = VEC_GENERAL;
		end
		CMD_TLB_MISS: begin
			shadow_fault_code(EXC_TLBL, 2'd0);
			shadow_load_vaddr(r.bad_address);
			shadow_regs[REG_ENTRYHI] = r.bad_address & MASK_ENTRYHI_M;
			o.redirect = 1'b1;
			if (!shadow_regs[REG_STATUS][1]) begin
				shadow_save_epc(r.current_pc, r.in_delay_slot);
				o.redirect_pc = r.address_mapped ? VEC_GENERAL : VEC_REFILL;
				shadow_regs[REG_STATUS][1] = 1'b1;
			end else begin
				// nested miss: EPC, BD and EXL stay as they are
				o.redirect_pc = VEC_GENERAL;
			end
		end
		default: ;  // unknown commands change nothing
		endcase
		st = shadow_regs[REG_STATUS];
		o.interrupt_request = st[0] && (st[2:1] == 2'b00) &&
			((st[15:8] & shadow_regs[REG_CAUSE][15:8]) != 8'd0);
		return o;
	endfunction

	// -------------------------------------------------------------- stimulus
	function automatic req_t cp0_req(logic [2:0] cmd, logic [4:0] idx, logic [63:0] val);
		req_t r;
		r = '0;
		r.command     = cmd;
		r.reg_index   = idx;
		r.write_value = val;
		return r;
	endfunction

	task automatic queue_op(req_t r, int unsigned gap);
		op_q.push_back('{cmd: r, hold_off: gap, drain: 1'b0});
	endtask

	task automatic queue_drain();
		op_q.push_back('{cmd: '0, hold_off: 0, drain: 1'b1});
	endtask

	task automatic log_mismatch(string msg);
		$display("mismatch: %s", msg);
		mismatch_count++;
	endtask

	// ---------------------------------------------------------------- driver
	// A request is taken at an edge with start high and busy low; the shadow
	// is advanced at that same edge so its order matches the core's.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start     <= 1'b0;
			req       <= '0;
			idle_left <= 0;
			for (ri = 0; ri < 32; ri++)
				shadow_regs[ri] = '0;
			shadow_last_wr          = '0;
			shadow_regs[REG_RANDOM]   = 64'h1F;
			shadow_regs[REG_COUNT]    = 64'h5000;
			shadow_regs[REG_CAUSE]    = 64'h5C;
			shadow_regs[REG_CONTEXT]  = 64'h007F_FFF0;
			shadow_regs[REG_EPC]      = '1;
			shadow_regs[REG_BADVADDR] = '1;
			shadow_regs[REG_ERROREPC] = '1;
			shadow_regs[REG_PRID]     = 64'hB22;
			shadow_regs[REG_CONFIG]   = 64'h7006_E463;
			shadow_regs[REG_STATUS]   = 64'h3400_0000;
		end else begin
			if (start && !busy)
				cp0_result_q.push_back(predict_cp0_result(req));

			if (start && busy) begin
				// request not taken yet: hold it
			end else if (idle_left != 0) begin
				start     <= 1'b0;
				idle_left <= idle_left - 1;
			end else if (op_q.size() != 0 && op_q[0].drain) begin
				// hold off until the core has answered everything
				start <= 1'b0;
				if (cp0_result_q.size() == 0)
					next_op = op_q.pop_front();
			end else if (op_q.size() != 0) begin
				next_op   = op_q.pop_front();
				start     <= 1'b1;
				req       <= next_op.cmd;
				idle_left <= next_op.hold_off;
			end else begin
				start <= 1'b0;
			end
		end
	end

	// --------------------------------------------------------------- monitor
	// done is high for exactly one cycle per result; there is no back-pressure.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_count <= 0;
		end else if (done === 1'b1) begin
			if (cp0_result_q.size() == 0) begin
				log_mismatch($sformatf("result %0d arrived with no request pending",
					result_count));
			end else begin
				want = cp0_result_q.pop_front();
				if (res.read_data !== want.read_data)
					log_mismatch($sformatf("result %0d read_data %h, predicted %h",
						result_count, res.read_data, want.read_data));
				if (res.redirect !== want.redirect)
					log_mismatch($sformatf("result %0d redirect %b, predicted %b",
						result_count, res.redirect, want.redirect));
				if (res.redirect_pc !== want.redirect_pc)
					log_mismatch($sformatf("result %0d redirect_pc %h, predicted %h",
						result_count, res.redirect_pc, want.redirect_pc));
				if (res.interrupt_request !== want.interrupt_request)
					log_mismatch($sformatf("result %0d interrupt_request %b, predicted %b",
						result_count, res.interrupt_request, want.interrupt_request));
			end
			result_count <= result_count + 1;
		end
	end

	// Watchdog: far beyond the slowest legal run (every request followed by
	// the longest idle burst, plus drains and latency).
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	// --------------------------------------------------------------- control
	initial begin
		req_t        d;
		int unsigned pick;
		int unsigned gap;
		int unsigned n;
		bit          quiet;

		// Directed: reset values, reserved and read-only registers, the
		// Compare and Cause side effects, exception entries in and out of a
		// delay slot, nested and first-level TLB misses, unknown commands.
		queue_op(cp0_req(CMD_READ, REG_RANDOM, '0), 0);
		queue_op(cp0_req(CMD_READ, REG_CAUSE, '0), 0);
		queue_op(cp0_req(CMD_READ, REG_CONTEXT, '0), 1);
		queue_op(cp0_req(CMD_READ, REG_CONFIG, '0), 0);
		queue_op(cp0_req(CMD_READ, REG_EPC, '0), 0);
		queue_op(cp0_req(CMD_READ, REG_RSVD7, '0), 2);        // last write still zero
		queue_op(cp0_req(CMD_WRITE, REG_RSVD21, '1), 0);      // no storage, sets last write
		queue_op(cp0_req(CMD_READ, REG_RSVD25, '0), 0);
		queue_op(cp0_req(CMD_WRITE, REG_PRID, '0), 0);        // read-only
		queue_op(cp0_req(CMD_READ, REG_PRID, '0), 3);
		queue_op(cp0_req(CMD_WRITE, REG_STATUS, '1), 0);      // sets EXL too
		queue_op(cp0_req(CMD_WRITE, REG_COMPARE, '1), 0);     // clears IP7
		queue_op(cp0_req(CMD_WRITE, REG_CAUSE, '1), 0);       // value ignored
		d = cp0_req(CMD_EXCEPTION, '0, '0);
		d.exc_code = '1; d.coproc_unit = '1; d.in_delay_slot = 1'b1; // pc 0 wraps
		queue_op(d, 0);
		d = cp0_req(CMD_ADDR_ERR, '0, '0);
		d.is_read_access = 1'b1; d.bad_address = '1; d.current_pc = 32'h7FFF_FFFF;
		queue_op(d, 0);
		d = cp0_req(CMD_ADDR_ERR, '0, '0);
		d.current_pc = '1; d.in_delay_slot = 1'b1;
		queue_op(d, 1);
		d = cp0_req(CMD_TLB_MISS, '0, '0);                     // EXL already set
		d.bad_address = 64'hA5A5_5A5A_F0F0_0F0F; d.current_pc = 32'h1234_5678;
		queue_op(d, 0);
		queue_op(cp0_req(CMD_WRITE, REG_STATUS, 64'h1), 0);   // IE on, EXL off
		d = cp0_req(CMD_TLB_MISS, '0, '0);                     // refill vector
		d.bad_address = 64'h5A5A_A5A5_0F0F_F0F0; d.current_pc = 32'h8000_0004;
		d.in_delay_slot = 1'b1;
		queue_op(d, 0);
		queue_op(cp0_req(CMD_WRITE, REG_STATUS, '0), 0);
		d = cp0_req(CMD_TLB_MISS, '0, '0);                     // mapped: general vector
		d.bad_address = '1; d.address_mapped = 1'b1; d.current_pc = '1;
		queue_op(d, 0);
		queue_op('1 & cp0_req(CMD_UNUSED_LO, '1, '1), 0);
		d = '1;
		d.command = CMD_UNUSED_HI;
		queue_op(d, 0);
		queue_op(cp0_req(CMD_READ, REG_XCONTEXT, '0), 0);
		queue_op(cp0_req(CMD_READ, REG_BADVADDR, '0), 0);
		queue_drain();

		// Random mix. Status writes often clear EXL/ERL so that TLB misses
		// reach the refill path and interrupts can be enabled. Idle bursts
		// come and go in phases; the tail runs back to back.
		for (n = 0; n < RANDOM_OPS; n++) begin
			if (n == 150 || n == 300)
				queue_drain();
			d.command        = CMD_READ;
			d.reg_index      = 5'($urandom_range(0, 31));
			d.write_value    = {$urandom, $urandom};
			d.exc_code       = 5'($urandom_range(0, 31));
			d.coproc_unit    = 2'($urandom_range(0, 3));
			d.in_delay_slot  = 1'($urandom_range(0, 1));
			d.current_pc     = $urandom;
			d.bad_address    = {$urandom, $urandom};
			d.is_read_access = 1'($urandom_range(0, 1));
			d.address_mapped = 1'($urandom_range(0, 1));
			pick = $urandom_range(0, 99);
			if (pick < 25) begin
				d.command = CMD_READ;
			end else if (pick < 55) begin
				d.command = CMD_WRITE;
				if ($urandom_range(0, 3) == 0) begin
					d.reg_index = REG_STATUS;
					if ($urandom_range(0, 1))
						d.write_value[2:1] = 2'b00;
				end
			end else if (pick < 67) begin
				d.command = CMD_EXCEPTION;
			end else if (pick < 79) begin
				d.command = CMD_ADDR_ERR;
			end else if (pick < 94) begin
				d.command = CMD_TLB_MISS;
			end else begin
				d.command = 3'($urandom_range(CMD_UNUSED_LO, CMD_UNUSED_HI));
			end
			quiet = (n >= 120 && n < 220) || n >= 320;
			gap = (!quiet && $urandom_range(0, 9) < 3) ? $urandom_range(1, 17) : 0;
			queue_op(d, gap);
		end

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// Everything sent and answered, then a settling wait for stray results.
		do
			@(posedge clk);
		while (op_q.size() != 0 || start || cp0_result_q.size() != 0);
		repeat (SETTLE_CLKS) @(posedge clk);

		if (mismatch_count == 0 && cp0_result_q.size() == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

/* sim.f */
hdl/mcp0_pkg.sv
hdl/mcp0_regfile.sv
hdl/mips_cp0_register_file_core.sv
hdl/mcp0_checker.sv
bench/mips_cp0_register_file_core_test.sv
